/* rtl/append_write_combining_buffer_defines.svh */
// assertion macros for the append write-combining buffer
`ifndef APPEND_WRITE_COMBINING_BUFFER_DEFINES_SVH
`define APPEND_WRITE_COMBINING_BUFFER_DEFINES_SVH
`ifndef SYNTHESIS
`define AWCB_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`define AWCB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define AWCB_ASSERT_SAME(lbl, ante, cons, msg)
`define AWCB_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* rtl/awcb_pkg.sv */
// types and constants of the append write-combining buffer
package awcb_pkg;

    localparam int DEF_STORE_DEPTH = 1024;
    localparam int DEF_PAGE_WORDS  = 16;
    localparam int DEF_WORD_WIDTH  = 64;

    localparam int DATA_W  = 64;
    localparam int INDEX_W = 10;
    localparam int COUNT_W = 11;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_LOAD   = 2'd1,
        OP_FLUSH  = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FLUSH,
        ST_APPEND,
        ST_LOAD
    } state_t;

endpackage

/* rtl/append_write_combining_buffer.sv */
// append write-combining buffer: one page in front of an append-only word store
// append, page-hit load, rejected request: result registered in the cycle after accept
// load served from the store: store read port registered, then the result register
// flush: one page word walked per cycle through the store write port
// page-leaving append: flush, then page write; next request in idle, output free or read
// sync reset clears mask, count and page pointers; store and page contents stay undefined
`include "append_write_combining_buffer_defines.svh"

module append_write_combining_buffer #(
    parameter int STORE_DEPTH = awcb_pkg::DEF_STORE_DEPTH,
    parameter int PAGE_WORDS  = awcb_pkg::DEF_PAGE_WORDS,
    parameter int WORD_WIDTH  = awcb_pkg::DEF_WORD_WIDTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,  // write_value [63:0], element_index [73:64]
    input  logic [1:0]  s_tuser,  // opcode [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,  // read_data [63:0], word_count [74:64]
    output logic [1:0]  m_tuser   // status [1:0]
);

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CW = $clog2(STORE_DEPTH + 1);
    localparam int SW = (PAGE_WORDS > 1) ? $clog2(PAGE_WORDS) : 1;
    localparam int EW = ((CW > awcb_pkg::INDEX_W) ? CW : awcb_pkg::INDEX_W) + 1;

    awcb_pkg::state_t state_reg, state_next;

    logic [WORD_WIDTH-1:0] store_mem [STORE_DEPTH];
    logic [WORD_WIDTH-1:0] page_mem  [PAGE_WORDS];

    logic [PAGE_WORDS-1:0] mask_reg, mask_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         cur_base_reg, cur_base_next;
    logic [CW-1:0]         app_base_reg, app_base_next;
    logic [SW-1:0]         app_slot_reg, app_slot_next;
    logic [SW-1:0]         flush_idx_reg, flush_idx_next;
    logic                  pend_app_reg, pend_app_next;
    logic [WORD_WIDTH-1:0] value_reg;
    logic [WORD_WIDTH-1:0] store_rd_reg;

    logic                          m_valid_reg, m_valid_next;
    logic [awcb_pkg::DATA_W-1:0]   m_data_reg;
    logic [awcb_pkg::COUNT_W-1:0]  m_count_reg;
    awcb_pkg::status_t             m_status_reg;

    logic                          s_accept;
    awcb_pkg::opcode_t             in_op;
    logic [WORD_WIDTH-1:0]         in_value;
    logic [EW-1:0]                 idx_ext;
    logic [EW-1:0]                 idx_off;
    logic                          full;
    logic                          need_flush;
    logic                          in_range;
    logic                          page_hit;
    logic                          flush_last;
    logic [EW-1:0]                 flush_pos;
    logic                          store_we;
    logic                          store_re;
    logic [SW-1:0]                 page_raddr;
    logic [WORD_WIDTH-1:0]         page_rdata;
    logic                          page_we;
    logic [WORD_WIDTH-1:0]         page_wdata;
    logic                          res_we;
    logic [WORD_WIDTH-1:0]         res_data;
    awcb_pkg::status_t             res_status;

    assign s_tready = (state_reg == awcb_pkg::ST_IDLE) && (!m_valid_reg || m_tready);
    assign s_accept = s_tvalid && s_tready;
    assign in_op    = awcb_pkg::opcode_t'(s_tuser);
    assign in_value = s_tdata[WORD_WIDTH-1:0];
    assign idx_ext  = EW'(s_tdata[64 +: awcb_pkg::INDEX_W]);
    assign idx_off  = idx_ext - EW'(cur_base_reg);

    assign full       = EW'(count_reg) >= EW'(STORE_DEPTH);
    assign need_flush = app_base_reg != cur_base_reg;
    assign in_range   = idx_ext < EW'(count_reg);
    assign page_hit   = (idx_ext >= EW'(cur_base_reg)) && (idx_off < EW'(PAGE_WORDS))
                        && mask_reg[idx_off[SW-1:0]];

    assign flush_last = flush_idx_reg == SW'(PAGE_WORDS - 1);
    assign flush_pos  = EW'(cur_base_reg) + EW'(flush_idx_reg);
    assign store_we   = (state_reg == awcb_pkg::ST_FLUSH) && mask_reg[flush_idx_reg]
                        && (flush_pos < EW'(STORE_DEPTH));
    assign store_re   = s_accept && (in_op == awcb_pkg::OP_LOAD) && in_range && !page_hit;

    assign page_raddr = (state_reg == awcb_pkg::ST_FLUSH) ? flush_idx_reg : idx_off[SW-1:0];
    assign page_rdata = page_mem[page_raddr];

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            awcb_pkg::ST_IDLE: begin
                if (s_accept) begin
                    case (in_op)
                        awcb_pkg::OP_APPEND: begin
                            if (!full && need_flush) begin
                                state_next = awcb_pkg::ST_FLUSH;
                            end
                        end
                        awcb_pkg::OP_LOAD: begin
                            if (in_range && !page_hit) begin
                                state_next = awcb_pkg::ST_LOAD;
                            end
                        end
                        awcb_pkg::OP_FLUSH: begin
                            state_next = awcb_pkg::ST_FLUSH;
                        end
                        default: begin
                            state_next = awcb_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            awcb_pkg::ST_FLUSH: begin
                if (flush_last) begin
                    state_next = pend_app_reg ? awcb_pkg::ST_APPEND : awcb_pkg::ST_IDLE;
                end
            end
            awcb_pkg::ST_APPEND: begin
                state_next = awcb_pkg::ST_IDLE;
            end
            awcb_pkg::ST_LOAD: begin
                state_next = awcb_pkg::ST_IDLE;
            end
            default: begin
                state_next = awcb_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and results
    always_comb begin
        mask_next      = mask_reg;
        count_next     = count_reg;
        cur_base_next  = cur_base_reg;
        app_base_next  = app_base_reg;
        app_slot_next  = app_slot_reg;
        flush_idx_next = flush_idx_reg;
        pend_app_next  = pend_app_reg;
        page_we        = 1'b0;
        page_wdata     = in_value;
        res_we         = 1'b0;
        res_data       = '0;
        res_status     = awcb_pkg::STAT_OK;
        unique case (state_reg)
            awcb_pkg::ST_IDLE: begin
                if (s_accept) begin
                    flush_idx_next = '0;
                    case (in_op)
                        awcb_pkg::OP_APPEND: begin
                            if (full) begin
                                res_we     = 1'b1;
                                res_status = awcb_pkg::STAT_FULL;
                            end else if (need_flush) begin
                                pend_app_next = 1'b1;
                            end else begin
                                page_we                 = 1'b1;
                                mask_next[app_slot_reg] = 1'b1;
                                count_next              = count_reg + 1'b1;
                                res_we                  = 1'b1;
                            end
                        end
                        awcb_pkg::OP_LOAD: begin
                            if (!in_range) begin
                                res_we     = 1'b1;
                                res_status = awcb_pkg::STAT_RANGE;
                            end else if (page_hit) begin
                                res_we   = 1'b1;
                                res_data = page_rdata;
                            end
                        end
                        awcb_pkg::OP_FLUSH: begin
                            pend_app_next = 1'b0;
                        end
                        default: begin
                            res_we = 1'b1;
                        end
                    endcase
                end
            end
            awcb_pkg::ST_FLUSH: begin
                flush_idx_next = flush_last ? '0 : flush_idx_reg + 1'b1;
                if (flush_last && !pend_app_reg) begin
                    res_we = 1'b1;
                end
            end
            awcb_pkg::ST_APPEND: begin
                page_we                 = 1'b1;
                page_wdata              = value_reg;
                cur_base_next           = app_base_reg;
                mask_next               = '0;
                mask_next[app_slot_reg] = 1'b1;
                count_next              = count_reg + 1'b1;
                pend_app_next           = 1'b0;
                res_we                  = 1'b1;
            end
            awcb_pkg::ST_LOAD: begin
                res_we   = 1'b1;
                res_data = store_rd_reg;
            end
            default: begin
                res_we = 1'b0;
            end
        endcase
        if (page_we) begin
            if (app_slot_reg == SW'(PAGE_WORDS - 1)) begin
                app_slot_next = '0;
                app_base_next = app_base_reg + CW'(PAGE_WORDS);
            end else begin
                app_slot_next = app_slot_reg + 1'b1;
            end
        end
        m_valid_next = res_we ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= awcb_pkg::ST_IDLE;
            mask_reg      <= '0;
            count_reg     <= '0;
            cur_base_reg  <= '0;
            app_base_reg  <= '0;
            app_slot_reg  <= '0;
            flush_idx_reg <= '0;
            pend_app_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            mask_reg      <= mask_next;
            count_reg     <= count_next;
            cur_base_reg  <= cur_base_next;
            app_base_reg  <= app_base_next;
            app_slot_reg  <= app_slot_next;
            flush_idx_reg <= flush_idx_next;
            pend_app_reg  <= pend_app_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            value_reg <= in_value;
        end
        if (res_we) begin
            m_data_reg   <= awcb_pkg::DATA_W'(res_data);
            m_count_reg  <= awcb_pkg::COUNT_W'(count_next);
            m_status_reg <= res_status;
        end
    end

    always_ff @(posedge aclk) begin
        if (page_we) begin
            page_mem[app_slot_reg] <= page_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (store_we) begin
            store_mem[flush_pos[AW-1:0]] <= page_rdata;
        end
        if (store_re) begin
            store_rd_reg <= store_mem[idx_ext[AW-1:0]];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, m_count_reg, m_data_reg};
    assign m_tuser  = m_status_reg;

    `AWCB_ASSERT_SAME(a_busy_not_ready, state_reg != awcb_pkg::ST_IDLE, !s_tready, "ready while busy")
    `AWCB_ASSERT_SAME(a_count_bound, 1'b1, EW'(count_reg) <= EW'(STORE_DEPTH), "count past depth")
    `AWCB_ASSERT_NEXT(a_append_count, s_accept && in_op == awcb_pkg::OP_APPEND && !full && !need_flush, count_reg == $past(count_reg) + 1'b1, "append did not count")
    `AWCB_ASSERT_NEXT(a_append_mask, state_reg == awcb_pkg::ST_APPEND, mask_reg != '0 && cur_base_reg == app_base_reg || app_slot_reg == '0, "page move lost mask")
    `AWCB_ASSERT_SAME(a_result_slot_free, res_we, !m_valid_reg || m_tready, "result overwrites pending output")

endmodule
